/* rtl/compass_heading_from_xy_macros.svh */
// ---------------------------------------------------------------------------
// Compass heading assertion macros
// Property checks that vanish when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef COMPASS_HEADING_FROM_XY_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CHC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("compass heading check failed");
// The consequent must hold in the cycle after the antecedent.
`define CHC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("compass heading check failed");
`else
`define CHC_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define CHC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/chc_pkg.sv */
// ---------------------------------------------------------------------------
// Compass heading package
// Angle formats, constants and the arctangent table shared by the pipeline.
// ---------------------------------------------------------------------------
package chc_pkg;

	// Angle accumulator: signed, units of 2^-20 degree.
	localparam int ANG_FRAC  = 20;
	localparam int ZW        = 30;
	localparam int TABLE_LEN = 24;

	// Samples are scaled by 256 before the rotations; two more bits hold the growth.
	localparam int SCALE_SHIFT = 8;
	localparam int X_MARGIN    = SCALE_SHIFT + 2;

	// Heading output format, 1/64 degree.
	localparam int HEAD_W   = 15;
	localparam int HEAD_LSB = ANG_FRAC - 6;

	localparam logic signed [ZW-1:0] DEG180 = ZW'(180) <<< ANG_FRAC;
	localparam logic signed [ZW-1:0] DEG360 = ZW'(360) <<< ANG_FRAC;
	localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(23040);
	localparam logic [HEAD_W-1:0] HALF_TURN = HEAD_W'(11520);

	// atan(2^-i) in units of 2^-20 degree.
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
		30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
		30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
		30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
		30'sd917,      30'sd458,      30'sd229,      30'sd115,
		30'sd57,       30'sd29,       30'sd14,       30'sd7
	};

	// Side-band flags that travel with each item through the rotations.
	typedef struct packed {
		logic byp;   // heading is fixed, the rotations are ignored
		logic half;  // fixed heading is 180 degrees rather than 0
	} ctl_t;

endpackage

/* rtl/chc_sample_if.sv */
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one X,Y field sample pair.
// ---------------------------------------------------------------------------
interface chc_sample_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] mag_x_sample;
	logic signed [W-1:0] mag_y_sample;

	modport source (output valid, output mag_x_sample, output mag_y_sample, input ready);
	modport sink   (input valid, input mag_x_sample, input mag_y_sample, output ready);
endinterface

/* rtl/chc_heading_if.sv */
// ---------------------------------------------------------------------------
// Heading channel
// Valid/ready channel carrying one compass heading in 1/64 degree.
// ---------------------------------------------------------------------------
interface chc_heading_if;
	logic                         valid;
	logic                         ready;
	logic [chc_pkg::HEAD_W-1:0]   heading;

	modport source (output valid, output heading, input ready);
	modport sink   (input valid, input heading, output ready);
endinterface

/* rtl/compass_heading_from_xy.sv */
// Throughput: one sample pair per cycle while the output does not stall; one
// register stage per micro-rotation, plus a front stage (gain and half-plane turn)
// and an output stage (wrap, round).
// A stall at the output holds only the stages that are full; bubbles close up.
// Reset clears all valid bits and sets the gain sign to +1.
// ---------------------------------------------------------------------------
// Compass heading from X,Y
// Pipelined CORDIC giving atan2(y, x) as a heading in 1/64 degree.
// ---------------------------------------------------------------------------
`include "compass_heading_from_xy_macros.svh"

module compass_heading_from_xy #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata,
	chc_sample_if.sink    sample,
	chc_heading_if.source result
);

	localparam int XW = SAMPLE_WIDTH + chc_pkg::X_MARGIN;

	logic [1:0]                    gain_q;
	logic                          v_c   [CORDIC_STEPS+1];
	logic                          rdy_c [CORDIC_STEPS+1];
	chc_pkg::ctl_t                 ctl_c [CORDIC_STEPS+1];
	logic signed [XW-1:0]          x_c   [CORDIC_STEPS+1];
	logic signed [XW-1:0]          y_c   [CORDIC_STEPS+1];
	logic signed [chc_pkg::ZW-1:0] z_c   [CORDIC_STEPS+1];

	// Gain sign register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 2'b01;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// Front stage.
	chc_front #(
		.W  (SAMPLE_WIDTH),
		.XW (XW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.x_in      (sample.mag_x_sample),
		.y_in      (sample.mag_y_sample),
		.gain      (gain_q),
		.out_valid (v_c[0]),
		.out_ready (rdy_c[0]),
		.ctl_out   (ctl_c[0]),
		.x_out     (x_c[0]),
		.y_out     (y_c[0]),
		.z_out     (z_c[0])
	);

	// Micro-rotation stages.
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
		chc_stage #(
			.XW   (XW),
			.STEP (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[g]),
			.in_ready  (rdy_c[g]),
			.ctl_in    (ctl_c[g]),
			.x_in      (x_c[g]),
			.y_in      (y_c[g]),
			.z_in      (z_c[g]),
			.out_valid (v_c[g+1]),
			.out_ready (rdy_c[g+1]),
			.ctl_out   (ctl_c[g+1]),
			.x_out     (x_c[g+1]),
			.y_out     (y_c[g+1]),
			.z_out     (z_c[g+1])
		);
	end

	// Output stage.
	chc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c[CORDIC_STEPS]),
		.in_ready (rdy_c[CORDIC_STEPS]),
		.ctl_in   (ctl_c[CORDIC_STEPS]),
		.z_in     (z_c[CORDIC_STEPS]),
		.result   (result)
	);

	// An empty output register never holds back the input.
	`CHC_ASSERT_NOW(a_no_idle_stall, clk, arst_n, !result.valid, sample.ready)
	// The heading always lies within one turn.
	`CHC_ASSERT_NOW(a_heading_range, clk, arst_n, result.valid,
		result.heading < chc_pkg::FULL_TURN)
	// A fixed zero heading reaches the output unchanged.
	`CHC_ASSERT_NEXT(a_zero_bypass, clk, arst_n,
		v_c[CORDIC_STEPS] && rdy_c[CORDIC_STEPS] && ctl_c[CORDIC_STEPS].byp &&
		!ctl_c[CORDIC_STEPS].half,
		result.valid && (result.heading == '0))

endmodule

/* rtl/chc_front.sv */
// ---------------------------------------------------------------------------
// Compass heading front end
// Applies the gain sign, detects the fixed-heading cases and turns the
// vector into the right half plane before the rotations.
// ---------------------------------------------------------------------------
module chc_front #(
	parameter int W  = 16,
	parameter int XW = 26
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [W-1:0]          x_in,
	input  logic signed [W-1:0]          y_in,
	input  logic        [1:0]            gain,
	output logic                         out_valid,
	input  logic                         out_ready,
	output chc_pkg::ctl_t                ctl_out,
	output logic signed [XW-1:0]         x_out,
	output logic signed [XW-1:0]         y_out,
	output logic signed [chc_pkg::ZW-1:0] z_out
);

	logic                         gain_neg;
	logic                         gain_zero;
	logic                         x_neg;
	logic                         flip;
	logic signed [W:0]            x_ext;
	logic signed [W:0]            y_ext;
	logic signed [W:0]            x_rot;
	logic signed [W:0]            y_rot;
	logic                         v_s1;
	chc_pkg::ctl_t                ctl_s1;
	logic signed [XW-1:0]         x_s1;
	logic signed [XW-1:0]         y_s1;
	logic signed [chc_pkg::ZW-1:0] z_s1;

	// Sign of x after the gain has been applied; a negative gain flips both axes.
	assign gain_neg  = gain[1];
	assign gain_zero = (gain == 2'b00);
	assign x_neg     = gain_neg ? (!x_in[W-1] && (x_in != '0)) : x_in[W-1];
	assign flip      = gain_neg ^ x_neg;

	// One negation covers both the gain and the half-plane turn.
	assign x_ext = (W+1)'(x_in);
	assign y_ext = (W+1)'(y_in);
	assign x_rot = flip ? -x_ext : x_ext;
	assign y_rot = flip ? -y_ext : y_ext;

	assign in_ready = !v_s1 || out_ready;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Payload of the stage; scaled by 256 on the way in.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_s1.byp  <= gain_zero || (y_in == '0);
			ctl_s1.half <= !gain_zero && x_neg;
			x_s1        <= XW'(x_rot) <<< chc_pkg::SCALE_SHIFT;
			y_s1        <= XW'(y_rot) <<< chc_pkg::SCALE_SHIFT;
			z_s1        <= x_neg ? chc_pkg::DEG180 : '0;
		end
	end

	assign out_valid = v_s1;
	assign ctl_out   = ctl_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign z_out     = z_s1;

endmodule

/* rtl/chc_stage.sv */
// ---------------------------------------------------------------------------
// Compass heading CORDIC stage
// One vectoring micro-rotation by atan(2^-STEP), registered.
// ---------------------------------------------------------------------------
module chc_stage #(
	parameter int XW   = 26,
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  chc_pkg::ctl_t                 ctl_in,
	input  logic signed [XW-1:0]          x_in,
	input  logic signed [XW-1:0]          y_in,
	input  logic signed [chc_pkg::ZW-1:0] z_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output chc_pkg::ctl_t                 ctl_out,
	output logic signed [XW-1:0]          x_out,
	output logic signed [XW-1:0]          y_out,
	output logic signed [chc_pkg::ZW-1:0] z_out
);

	// Registers of this stage; the stage number is STEP plus two.
	logic                          v_sn;
	chc_pkg::ctl_t                 ctl_sn;
	logic signed [XW-1:0]          x_sn;
	logic signed [XW-1:0]          y_sn;
	logic signed [chc_pkg::ZW-1:0] z_sn;
	logic signed [XW-1:0]          x_sh;
	logic signed [XW-1:0]          y_sh;
	logic                          y_pos;

	assign x_sh  = x_in >>> STEP;
	assign y_sh  = y_in >>> STEP;
	assign y_pos = !y_in[XW-1];

	assign in_ready = !v_sn || out_ready;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (in_ready) begin
			v_sn <= in_valid;
		end
	end

	// Rotate towards the x axis and accumulate the angle turned through.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_sn <= ctl_in;
			if (y_pos) begin
				x_sn <= x_in + y_sh;
				y_sn <= y_in - x_sh;
				z_sn <= z_in + chc_pkg::ATAN_TAB[STEP];
			end else begin
				x_sn <= x_in - y_sh;
				y_sn <= y_in + x_sh;
				z_sn <= z_in - chc_pkg::ATAN_TAB[STEP];
			end
		end
	end

	assign out_valid = v_sn;
	assign ctl_out   = ctl_sn;
	assign x_out     = x_sn;
	assign y_out     = y_sn;
	assign z_out     = z_sn;

endmodule

/* rtl/chc_back.sv */
// ---------------------------------------------------------------------------
// Compass heading back end
// Wraps the angle into one turn, rounds to 1/64 degree and holds the result.
// ---------------------------------------------------------------------------
module chc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  chc_pkg::ctl_t                 ctl_in,
	input  logic signed [chc_pkg::ZW-1:0] z_in,
	chc_heading_if.source                 result
);

	localparam int UW = chc_pkg::ZW - 1;

	logic                          v_q;
	logic [chc_pkg::HEAD_W-1:0]    heading_q;
	logic signed [chc_pkg::ZW-1:0] z_wrap;
	logic [UW-1:0]                 z_round;
	logic [chc_pkg::HEAD_W-1:0]    h_raw;
	logic [chc_pkg::HEAD_W-1:0]    h_next;

	// The angle never reaches a full turn, so only negative values need wrapping.
	assign z_wrap  = z_in[chc_pkg::ZW-1] ? (z_in + chc_pkg::DEG360) : z_in;
	assign z_round = UW'(z_wrap) + (UW'(1) << (chc_pkg::HEAD_LSB - 1));
	assign h_raw   = z_round[chc_pkg::HEAD_LSB +: chc_pkg::HEAD_W];

	// Fixed headings bypass the rotations; a full turn rounds back to zero.
	always_comb begin
		if (ctl_in.byp) begin
			h_next = ctl_in.half ? chc_pkg::HALF_TURN : '0;
		end else if (h_raw >= chc_pkg::FULL_TURN) begin
			h_next = '0;
		end else begin
			h_next = h_raw;
		end
	end

	assign in_ready = !v_q || result.ready;

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	// Output heading.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			heading_q <= h_next;
		end
	end

	assign result.valid   = v_q;
	assign result.heading = heading_q;

endmodule
